@@ rtl/sac_pkg.sv @@
// shared types and codes of the set-associative cache tag controller
`timescale 1ns / 1ps

package sac_pkg;

    // access codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_INVAL = 2'd2;

    // replacement policy codes, any other code acts as lru
    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;
    localparam logic [1:0] POL_RAND = 2'd2;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef logic [15:0] lfsr_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SPLIT  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    // fibonacci lfsr, taps 16 14 13 11
    function automatic lfsr_t lfsr_step(input lfsr_t l);
        lfsr_step = {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
    endfunction

endpackage

@@ rtl/sac_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/sac_cdiv.sv @@
// divide by a constant: a shift for powers of two, else reciprocal multiply, then remainder
`timescale 1ns / 1ps

module sac_cdiv #(
    parameter int IN_W    = 26,
    parameter int DIVISOR = 64,
    parameter int Q_W     = 20,
    parameter int R_W     = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [IN_W-1:0] dividend,
    output logic            busy,
    output logic [Q_W-1:0]  quot,
    output logic [R_W-1:0]  rem
);

    localparam bit POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

    generate
        if (POW2)
        begin : g_shift
            logic [Q_W-1:0] quot_reg;
            logic [R_W-1:0] rem_reg;
            logic           busy_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    quot_reg <= Q_W'(dividend / DIVISOR);
                    rem_reg  <= R_W'(dividend % DIVISOR);
                end
            end

            assign busy = busy_reg;
            assign quot = quot_reg;
            assign rem  = rem_reg;
        end
        else
        begin : g_recip
            localparam int L  = $clog2(DIVISOR);
            localparam int K  = IN_W + L;
            localparam int MW = IN_W + 2;
            localparam int PW = IN_W + MW;
            localparam logic [63:0] MUL =
                ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
            localparam logic [MW-1:0]   MUL_C = MW'(MUL);
            localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

            logic [IN_W-1:0] x_reg;
            logic [IN_W-1:0] q_reg;
            logic [R_W-1:0]  r_reg;
            logic            busy_reg;
            logic            phase_reg;
            logic [PW-1:0]   prod;
            logic [IN_W-1:0] back;

            // high part of x * ceil(2^K / DIVISOR) is the exact quotient for any IN_W-bit x
            assign prod = PW'(x_reg) * PW'(MUL_C);
            // remainder is exact modulo 2^IN_W, and it always fits there
            assign back = q_reg * DIV_C;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg  <= 1'b0;
                    phase_reg <= 1'b0;
                end
                else if (start)
                begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                end
                else if (busy_reg)
                begin
                    if (phase_reg)
                    begin
                        busy_reg  <= 1'b0;
                        phase_reg <= 1'b0;
                    end
                    else
                    begin
                        phase_reg <= 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    x_reg <= dividend;
                end
                else if (busy_reg && !phase_reg)
                begin
                    q_reg <= IN_W'(prod >> K);
                end
                else if (busy_reg && phase_reg)
                begin
                    r_reg <= R_W'(x_reg - back);
                end
            end

            assign busy = busy_reg;
            assign quot = Q_W'(q_reg);
            assign rem  = r_reg;
        end
    endgenerate

endmodule

@@ rtl/set_assoc_cache_tag_controller.sv @@
// top level of the set-associative cache tag controller
`timescale 1ns / 1ps

// Tag side of a write-through, write-allocate set-associative cache. One word
// in is a read, a write or an invalidate-all with a byte address; one word out
// gives hit, way, fill, eviction and write-through flags. Tags sit in one ram
// and valid bits plus the per-set replacement order in another, both read and
// modified once per access; the order row is written back on every access, the
// tag row only on a miss. One access is in flight at a time. With SETS a power
// of two an access is accepted with the ram read, then updated; otherwise the
// set/tag split first goes through a two-stage reciprocal multiplication. The
// update waits while the previous result is still held, and the next word is
// accepted only after the update. The victim for the next random eviction is
// computed ahead from the lfsr and holds an access only until ready. After reset
// and after each invalidate-all the valid/order ram is swept clear, one set per
// cycle, while no word is accepted. A result waits in an output register.

module set_assoc_cache_tag_controller #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 5,
    parameter int ADDR_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [1:0]  way,
    output logic        filled,
    output logic        evicted,
    output logic        memory_write
);

    localparam int  AEFF      = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int  LINE_W    = (AEFF > OFFSET_BITS) ? AEFF - OFFSET_BITS : 1;
    localparam bit  SETS_POW2 = (SETS & (SETS - 1)) == 0;
    localparam int  SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int  SHIFT_W   = SETS_POW2 ? $clog2(SETS) : $clog2(SETS) - 1;
    localparam int  TAG_W     = (LINE_W > SHIFT_W) ? LINE_W - SHIFT_W : 1;
    localparam int  WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  CNT_W     = $clog2(WAYS + 1);
    localparam int  META_W    = CNT_W + WAYS * WAY_W + WAYS;
    localparam int  TROW_W    = WAYS * TAG_W;
    localparam logic [31:0] AMASK = 32'((64'(1) << AEFF) - 64'(1));

    sac_pkg::state_t state_reg, state_next;

    logic [1:0]       policy_reg;
    sac_pkg::lfsr_t   lfsr_reg;
    logic             lfsr_kick_reg;
    logic [1:0]       act_reg;
    logic [SET_W-1:0] clr_reg;

    logic             in_fire;
    logic [31:0]      line_full;
    logic [LINE_W-1:0] line_in;
    logic [SET_W-1:0] comb_set;

    logic             split_busy;
    logic [TAG_W-1:0] split_tag;
    logic [SET_W-1:0] split_set;
    logic             mod_busy;
    logic [WAY_W-1:0] mod_way;
    logic             mod_ready;

    logic [SET_W-1:0]  meta_raddr, meta_waddr;
    logic [META_W-1:0] meta_rdata, meta_wdata;
    logic              meta_we;
    logic [TROW_W-1:0] tag_rdata, tag_wdata;
    logic              tag_we;

    logic [WAYS-1:0]  valid_v, valid_new;
    logic [WAY_W-1:0] ord [WAYS+1];
    logic [WAY_W-1:0] ord_new [WAYS];
    logic [TAG_W-1:0] tags [WAYS];
    logic [CNT_W-1:0] cnt, cnt_new, pos;
    logic             found;
    logic             hit_any, inv_any;
    logic [WAY_W-1:0] hit_way, inv_way, sel_way;
    logic             is_fifo, is_rand, is_lru;
    logic             need_rand, access, out_free, go, lfsr_adv;

    assign in_ready = state_reg == sac_pkg::ST_IDLE;
    assign in_fire  = in_valid && in_ready;

    assign line_full = (addr & AMASK) >> OFFSET_BITS;
    assign line_in   = LINE_W'(line_full);
    assign comb_set  = SET_W'(line_in & LINE_W'(SETS - 1));

    sac_cdiv #(
        .IN_W    (LINE_W),
        .DIVISOR (SETS),
        .Q_W     (TAG_W),
        .R_W     (SET_W)
    ) u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .dividend (line_in),
        .busy     (split_busy),
        .quot     (split_tag),
        .rem      (split_set)
    );

    // victim for the next random eviction, ready ahead of time
    sac_cdiv #(
        .IN_W    (16),
        .DIVISOR (WAYS),
        .Q_W     (16),
        .R_W     (WAY_W)
    ) u_victim (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lfsr_kick_reg),
        .dividend (sac_pkg::lfsr_step(lfsr_reg)),
        .busy     (mod_busy),
        .quot     (),
        .rem      (mod_way)
    );

    assign mod_ready = !mod_busy && !lfsr_kick_reg;

    assign meta_raddr = (state_reg == sac_pkg::ST_IDLE) ? comb_set : split_set;

    sac_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    sac_ram #(
        .WIDTH (TROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (split_set),
        .wdata (tag_wdata),
        .raddr (meta_raddr),
        .rdata (tag_rdata)
    );

    // lookup and order update on the set row
    always_comb
    begin
        valid_v = meta_rdata[WAYS-1:0];
        cnt     = meta_rdata[META_W-1 -: CNT_W];
        for (int w = 0; w < WAYS; w++)
        begin
            ord[w]  = meta_rdata[WAYS + w * WAY_W +: WAY_W];
            tags[w] = tag_rdata[w * TAG_W +: TAG_W];
        end
        ord[WAYS] = '0;

        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_v[w] && tags[w] == split_tag)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_v[w])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end

        is_fifo   = policy_reg == sac_pkg::POL_FIFO;
        is_rand   = policy_reg == sac_pkg::POL_RAND;
        is_lru    = !is_fifo && !is_rand;
        need_rand = !hit_any && !inv_any && is_rand;

        if (hit_any)
        begin
            sel_way = hit_way;
        end
        else if (inv_any)
        begin
            sel_way = inv_way;
        end
        else if (is_rand)
        begin
            sel_way = mod_way;
        end
        else
        begin
            sel_way = ord[0];
        end

        // move sel_way to the back of the list, appending when absent
        found = 1'b0;
        pos   = cnt;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < cnt && ord[i] == sel_way)
            begin
                found = 1'b1;
                pos   = CNT_W'(i);
            end
        end
        cnt_new = found ? cnt : cnt + CNT_W'(1);
        for (int i = 0; i < WAYS; i++)
        begin
            ord_new[i] = (CNT_W'(i) >= pos) ? ord[i + 1] : ord[i];
            if (CNT_W'(i) == cnt_new - CNT_W'(1))
            begin
                ord_new[i] = sel_way;
            end
        end

        valid_new = valid_v;
        tag_wdata = tag_rdata;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == sel_way)
            begin
                valid_new[w] = 1'b1;
                tag_wdata[w * TAG_W +: TAG_W] = split_tag;
            end
        end

        meta_wdata[WAYS-1:0] = hit_any ? valid_v : valid_new;
        if (hit_any && !is_lru)
        begin
            meta_wdata[META_W-1:WAYS] = meta_rdata[META_W-1:WAYS];
        end
        else
        begin
            meta_wdata[META_W-1 -: CNT_W] = cnt_new;
            for (int i = 0; i < WAYS; i++)
            begin
                meta_wdata[WAYS + i * WAY_W +: WAY_W] = ord_new[i];
            end
        end

        if (state_reg == sac_pkg::ST_CLEAR)
        begin
            meta_wdata = '0;
        end
    end

    assign access   = act_reg == sac_pkg::ACT_READ || act_reg == sac_pkg::ACT_WRITE;
    assign out_free = !out_valid || out_ready;
    assign go       = state_reg == sac_pkg::ST_UPDATE && out_free
                      && !(access && need_rand && !mod_ready);
    assign lfsr_adv = go && access && need_rand;

    assign meta_we    = state_reg == sac_pkg::ST_CLEAR || (go && access);
    assign meta_waddr = (state_reg == sac_pkg::ST_CLEAR) ? clr_reg : split_set;
    assign tag_we     = go && access && !hit_any;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sac_pkg::ST_CLEAR:
            begin
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = SETS_POW2 ? sac_pkg::ST_UPDATE : sac_pkg::ST_SPLIT;
                end
            end
            sac_pkg::ST_SPLIT:
            begin
                if (!split_busy)
                begin
                    state_next = sac_pkg::ST_UPDATE;
                end
            end
            sac_pkg::ST_UPDATE:
            begin
                if (go)
                begin
                    state_next = (act_reg == sac_pkg::ACT_INVAL) ? sac_pkg::ST_CLEAR
                                                                 : sac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sac_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sac_pkg::ST_CLEAR;
            clr_reg       <= '0;
            policy_reg    <= sac_pkg::POL_LRU;
            lfsr_reg      <= sac_pkg::LFSR_SEED;
            lfsr_kick_reg <= 1'b1;
            out_valid     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lfsr_kick_reg <= lfsr_adv;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (lfsr_adv)
            begin
                lfsr_reg <= sac_pkg::lfsr_step(lfsr_reg);
            end
            if (state_reg == sac_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + SET_W'(1);
            end
            else if (go)
            begin
                clr_reg <= '0;
            end
            if (go)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= action;
        end
        if (go)
        begin
            hit          <= access && hit_any;
            way          <= access ? 2'(sel_way) : 2'd0;
            filled       <= access && !hit_any;
            evicted      <= access && !hit_any && !inv_any;
            memory_write <= act_reg == sac_pkg::ACT_WRITE;
        end
    end

`ifndef SYNTHESIS
    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !filled && !evicted)
        else $error("hit reported together with fill or eviction");

    a_evict_fills: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> filled)
        else $error("eviction without fill");

    a_lfsr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (lfsr_reg != $past(lfsr_reg)) |-> $past(lfsr_adv))
        else $error("lfsr moved without a random eviction");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sac_pkg::ST_CLEAR |-> !in_ready && meta_we)
        else $error("word accepted or no write during clearing sweep");
`endif

endmodule
